@@ hw/rtl/xxhash64_stream_hasher_assert.svh @@
// assertion macros used by the checker file
`ifndef XXHASH64_STREAM_HASHER_ASSERT_SVH
`define XXHASH64_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define XXH64_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("xxh64 assertion failed");

// next-cycle implication
`define XXH64_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("xxh64 assertion failed");

`endif

@@ hw/rtl/xxh64_pkg.sv @@
package xxh64_pkg;

  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

  // lane 0 start offset, wraps modulo 2^64
  localparam logic [63:0] LANE0_INIT = PRIME1 + PRIME2;

  localparam logic [5:0] STRIPE_BYTES = 6'd32;

  // partial product steps of the shared multiplier
  localparam logic [1:0] MUL_CROSS_A = 2'd0;
  localparam logic [1:0] MUL_CROSS_B = 2'd1;
  localparam logic [1:0] MUL_LOW     = 2'd2;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_LANE_A = 20'h00002,
    S_LANE_B = 20'h00004,
    S_DIG    = 20'h00008,
    S_CONV   = 20'h00010,
    S_MRG_A  = 20'h00020,
    S_MRG_B  = 20'h00040,
    S_MRG_C  = 20'h00080,
    S_ADDLEN = 20'h00100,
    S_TAIL   = 20'h00200,
    S_T8_A   = 20'h00400,
    S_T8_B   = 20'h00800,
    S_T8_C   = 20'h01000,
    S_T4_A   = 20'h02000,
    S_T4_B   = 20'h04000,
    S_T1_A   = 20'h08000,
    S_T1_B   = 20'h10000,
    S_AV_A   = 20'h20000,
    S_AV_B   = 20'h40000,
    S_EMIT   = 20'h80000
  } state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
    logic [127:0] d;
    d = {x, x} << n;
    return d[127:64];
  endfunction

endpackage

@@ hw/rtl/xxhash64_stream_hasher.sv @@
// xxh64 stream hasher: 64-bit xxHash over a byte message sent as a stream of requests.
// input channel: in_valid/in_stall with data_word, byte_count (0..BYTES_PER_ITEM, larger
// values count as BYTES_PER_ITEM) and last. bytes are little-endian, first in bits 7:0.
// output channel: out_valid/out_stall with hash, one digest after each request marked last.
// seed is written through cfg_wr_en/cfg_wr_data and is sampled at each message start.
// a request that does not complete a 32-byte stripe is stored in the stripe buffer. completing
// a stripe runs four lane rounds, each two 64-bit multiplies on the one
// shared 32x32 multiplier. a last request then runs the digest:
//   convergence and merge of the lanes (length >= 32), the length add, one step per tail
//   piece of 8, 4 or 1 bytes, and the avalanche, before out_valid.
// in_stall is low only while idle; a request that completes a stripe or is marked last
// keeps in_stall high until its lane rounds or its digest are done.
// the digest sits in an output register; the next message is accepted while it waits.
// a stalled out_valid holds hash; a new digest waits until the register is taken.
// rst (synchronous) clears the seed to zero, drops out_valid and starts a new message.
module xxhash64_stream_hasher #(
  parameter int BYTES_PER_ITEM = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [63:0]                 cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [8*BYTES_PER_ITEM-1:0] data_word,
  input  logic [3:0]                  byte_count,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 hash
);

  localparam int WORD_W = 8 * BYTES_PER_ITEM;
  localparam logic [3:0] MAX_CNT = 4'(BYTES_PER_ITEM);

  xxh64_pkg::state_t state;

  logic [63:0]       seed;
  logic [63:0]       lane [4];
  logic [7:0]        sbuf [32];
  logic [4:0]        fill;
  logic [63:0]       msg_len;
  logic              msg_start;

  logic [WORD_W-1:0] item_word;
  logic              item_last;
  logic [3:0]        n1_r;
  logic [3:0]        n2_r;

  logic [1:0]        k;
  logic [4:0]        pos;
  logic [63:0]       h;
  logic [63:0]       tmp;

  // shared multiplier
  logic [1:0]        mcnt;
  logic [31:0]       mx;
  logic              mul_run;
  logic              mul_done;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic [31:0]       px;
  logic [31:0]       py;
  logic [63:0]       pp;
  logic [63:0]       p;

  logic              accept;
  logic [3:0]        cnt_sat;
  logic [4:0]        fill_eff;
  logic [5:0]        room;
  logic [3:0]        n1;
  logic              stripe_full;
  logic [63:0]       in_word64;
  logic [63:0]       item_word64;
  logic              seg2_wr;
  logic              out_free;
  logic [4:0]        rd_pos;
  logic [63:0]       win;
  logic [63:0]       conv_term;
  logic [5:0]        pos6;
  logic [5:0]        fill6;
  logic              wr_en [32];
  logic [7:0]        wr_data [32];

  assign in_stall = (state != xxh64_pkg::S_IDLE);
  assign accept   = in_valid && (state == xxh64_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign cnt_sat     = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;
  assign fill_eff    = msg_start ? 5'd0 : fill;
  assign room        = xxh64_pkg::STRIPE_BYTES - {1'b0, fill_eff};
  assign n1          = ({2'b00, cnt_sat} <= room) ? cnt_sat : room[3:0];
  assign stripe_full = (({1'b0, fill_eff} + {2'b00, n1}) == xxh64_pkg::STRIPE_BYTES);
  assign in_word64   = 64'(data_word);
  assign item_word64 = 64'(item_word);
  assign seg2_wr     = (state == xxh64_pkg::S_LANE_B) && mul_done && (k == 2'd3);

  assign pos6  = {1'b0, pos};
  assign fill6 = {1'b0, fill};

  // one read window into the stripe buffer
  assign rd_pos = (state == xxh64_pkg::S_LANE_A) ? {k, 3'b000} : pos;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      win[8*i +: 8] = sbuf[rd_pos + 5'(i)];
    end
  end

  always_comb begin
    unique case (k)
      2'd0:    conv_term = xxh64_pkg::rotl64(lane[0], 6'd1);
      2'd1:    conv_term = xxh64_pkg::rotl64(lane[1], 6'd7);
      2'd2:    conv_term = xxh64_pkg::rotl64(lane[2], 6'd12);
      default: conv_term = xxh64_pkg::rotl64(lane[3], 6'd18);
    endcase
  end

  // first part of a request goes in at accept, the part past a stripe end after the rounds
  always_comb begin
    logic [4:0] off;
    logic [2:0] idx;
    for (int j = 0; j < 32; j++) begin
      off = 5'(j) - fill_eff;
      idx = 3'(j) + n1_r[2:0];
      if (accept) begin
        wr_en[j]   = (off < 5'(n1));
        wr_data[j] = in_word64[{off[2:0], 3'b000} +: 8];
      end else begin
        wr_en[j]   = seg2_wr && (5'(j) < 5'(n2_r));
        wr_data[j] = item_word64[{idx, 3'b000} +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 32; j++) begin
      if (wr_en[j]) begin
        sbuf[j] <= wr_data[j];
      end
    end
  end

  // operand select per step
  always_comb begin
    mul_run = 1'b1;
    mul_a   = h;
    mul_b   = xxh64_pkg::PRIME1;
    unique case (state)
      xxh64_pkg::S_LANE_A: begin
        mul_a = win;
        mul_b = xxh64_pkg::PRIME2;
      end
      xxh64_pkg::S_LANE_B: mul_a = tmp;
      xxh64_pkg::S_MRG_A: begin
        mul_a = lane[k];
        mul_b = xxh64_pkg::PRIME2;
      end
      xxh64_pkg::S_MRG_B: mul_a = tmp;
      xxh64_pkg::S_MRG_C: mul_a = h;
      xxh64_pkg::S_T8_A: begin
        mul_a = win;
        mul_b = xxh64_pkg::PRIME2;
      end
      xxh64_pkg::S_T8_B: mul_a = tmp;
      xxh64_pkg::S_T8_C: mul_a = xxh64_pkg::rotl64(h, 6'd27);
      xxh64_pkg::S_T4_A: mul_a = {32'd0, win[31:0]};
      xxh64_pkg::S_T4_B: begin
        mul_a = xxh64_pkg::rotl64(h, 6'd23);
        mul_b = xxh64_pkg::PRIME2;
      end
      xxh64_pkg::S_T1_A: begin
        mul_a = {56'd0, win[7:0]};
        mul_b = xxh64_pkg::PRIME5;
      end
      xxh64_pkg::S_T1_B: mul_a = xxh64_pkg::rotl64(h, 6'd11);
      xxh64_pkg::S_AV_A: begin
        mul_a = h ^ (h >> 33);
        mul_b = xxh64_pkg::PRIME2;
      end
      xxh64_pkg::S_AV_B: begin
        mul_a = h ^ (h >> 29);
        mul_b = xxh64_pkg::PRIME3;
      end
      default: mul_run = 1'b0;
    endcase
  end

  // low 64 bits of a 64x64 product from three 32x32 partial products
  always_comb begin
    unique case (mcnt)
      xxh64_pkg::MUL_CROSS_A: begin
        px = mul_a[31:0];
        py = mul_b[63:32];
      end
      xxh64_pkg::MUL_CROSS_B: begin
        px = mul_a[63:32];
        py = mul_b[31:0];
      end
      default: begin
        px = mul_a[31:0];
        py = mul_b[31:0];
      end
    endcase
  end

  assign pp       = {32'd0, px} * {32'd0, py};
  assign p        = pp + {mx, 32'd0};
  assign mul_done = mul_run && (mcnt == xxh64_pkg::MUL_LOW);

  always_ff @(posedge clk) begin
    if (mul_run) begin
      unique case (mcnt)
        xxh64_pkg::MUL_CROSS_A: mx <= pp[31:0];
        xxh64_pkg::MUL_CROSS_B: mx <= mx + pp[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xxh64_pkg::S_IDLE;
      seed      <= '0;
      fill      <= '0;
      msg_len   <= '0;
      msg_start <= 1'b1;
      k         <= '0;
      pos       <= '0;
      mcnt      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lane[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
      // the emit step reloads the register itself
      if (out_valid && !out_stall && (state != xxh64_pkg::S_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (mul_run) begin
        mcnt <= mul_done ? 2'd0 : mcnt + 2'd1;
      end

      unique case (state)
        xxh64_pkg::S_IDLE: begin
          if (accept) begin
            if (msg_start) begin
              lane[0] <= seed + xxh64_pkg::LANE0_INIT;
              lane[1] <= seed + xxh64_pkg::PRIME2;
              lane[2] <= seed;
              lane[3] <= seed - xxh64_pkg::PRIME1;
            end
            msg_len   <= (msg_start ? 64'd0 : msg_len) + 64'(cnt_sat);
            fill      <= fill_eff + 5'(n1);
            msg_start <= last;
            item_word <= data_word;
            item_last <= last;
            n1_r      <= n1;
            n2_r      <= cnt_sat - n1;
            k         <= '0;
            if (stripe_full) begin
              state <= xxh64_pkg::S_LANE_A;
            end else if (last) begin
              state <= xxh64_pkg::S_DIG;
            end
          end
        end
        xxh64_pkg::S_LANE_A: begin
          if (mul_done) begin
            tmp   <= xxh64_pkg::rotl64(lane[k] + p, 6'd31);
            state <= xxh64_pkg::S_LANE_B;
          end
        end
        xxh64_pkg::S_LANE_B: begin
          if (mul_done) begin
            lane[k] <= p;
            k       <= k + 2'd1;
            if (k == 2'd3) begin
              fill  <= 5'(n2_r);
              state <= item_last ? xxh64_pkg::S_DIG : xxh64_pkg::S_IDLE;
            end else begin
              state <= xxh64_pkg::S_LANE_A;
            end
          end
        end
        xxh64_pkg::S_DIG: begin
          k <= '0;
          if (msg_len[63:5] != '0) begin
            state <= xxh64_pkg::S_CONV;
          end else begin
            h     <= lane[2] + xxh64_pkg::PRIME5;
            state <= xxh64_pkg::S_ADDLEN;
          end
        end
        xxh64_pkg::S_CONV: begin
          h <= ((k == 2'd0) ? 64'd0 : h) + conv_term;
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= xxh64_pkg::S_MRG_A;
          end
        end
        xxh64_pkg::S_MRG_A: begin
          if (mul_done) begin
            tmp   <= xxh64_pkg::rotl64(p, 6'd31);
            state <= xxh64_pkg::S_MRG_B;
          end
        end
        xxh64_pkg::S_MRG_B: begin
          if (mul_done) begin
            h     <= h ^ p;
            state <= xxh64_pkg::S_MRG_C;
          end
        end
        xxh64_pkg::S_MRG_C: begin
          if (mul_done) begin
            h <= p + xxh64_pkg::PRIME4;
            k <= k + 2'd1;
            state <= (k == 2'd3) ? xxh64_pkg::S_ADDLEN : xxh64_pkg::S_MRG_A;
          end
        end
        xxh64_pkg::S_ADDLEN: begin
          h     <= h + msg_len;
          pos   <= '0;
          state <= xxh64_pkg::S_TAIL;
        end
        xxh64_pkg::S_TAIL: begin
          priority if (pos6 + 6'd8 <= fill6) begin
            state <= xxh64_pkg::S_T8_A;
          end else if (pos6 + 6'd4 <= fill6) begin
            state <= xxh64_pkg::S_T4_A;
          end else if (pos6 < fill6) begin
            state <= xxh64_pkg::S_T1_A;
          end else begin
            state <= xxh64_pkg::S_AV_A;
          end
        end
        xxh64_pkg::S_T8_A: begin
          if (mul_done) begin
            tmp   <= xxh64_pkg::rotl64(p, 6'd31);
            state <= xxh64_pkg::S_T8_B;
          end
        end
        xxh64_pkg::S_T8_B: begin
          if (mul_done) begin
            h     <= h ^ p;
            state <= xxh64_pkg::S_T8_C;
          end
        end
        xxh64_pkg::S_T8_C: begin
          if (mul_done) begin
            h     <= p + xxh64_pkg::PRIME4;
            pos   <= pos + 5'd8;
            state <= xxh64_pkg::S_TAIL;
          end
        end
        xxh64_pkg::S_T4_A: begin
          if (mul_done) begin
            h     <= h ^ p;
            state <= xxh64_pkg::S_T4_B;
          end
        end
        xxh64_pkg::S_T4_B: begin
          if (mul_done) begin
            h     <= p + xxh64_pkg::PRIME3;
            pos   <= pos + 5'd4;
            state <= xxh64_pkg::S_TAIL;
          end
        end
        xxh64_pkg::S_T1_A: begin
          if (mul_done) begin
            h     <= h ^ p;
            state <= xxh64_pkg::S_T1_B;
          end
        end
        xxh64_pkg::S_T1_B: begin
          if (mul_done) begin
            h     <= p;
            pos   <= pos + 5'd1;
            state <= xxh64_pkg::S_TAIL;
          end
        end
        xxh64_pkg::S_AV_A: begin
          if (mul_done) begin
            h     <= p;
            state <= xxh64_pkg::S_AV_B;
          end
        end
        xxh64_pkg::S_AV_B: begin
          if (mul_done) begin
            h     <= p ^ (p >> 32);
            state <= xxh64_pkg::S_EMIT;
          end
        end
        xxh64_pkg::S_EMIT: begin
          // wait for the output register to free up
          if (out_free) begin
            hash      <= h;
            out_valid <= 1'b1;
            state     <= xxh64_pkg::S_IDLE;
          end
        end
        default: state <= xxh64_pkg::S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/xxh64_checker.sv @@
`include "xxhash64_stream_hasher_assert.svh"

module xxh64_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] hash
);

  `XXH64_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(hash))
  `XXH64_ASSERT_NXT(a_reset_clears_out, clk, 1'b0, rst, !out_valid)
  `XXH64_ASSERT_NXT(a_last_makes_busy, clk, rst, in_valid && !in_stall && last, in_stall)
  `XXH64_ASSERT_NXT(a_no_instant_digest, clk, rst, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind xxhash64_stream_hasher xxh64_checker u_xxh64_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hash      (hash)
);
